>>> rtl/core/caom_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caom_pkg
// Shared types and constants for the centered alpha-over merge unit.
// ----------------------------------------------------------------------------
package caom_pkg;

    // Largest image side in pixels; register writes above it saturate.
    localparam int MAX_SIDE = 4096;
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
    localparam int COORD_W  = 12;
    localparam int CHAN_W   = 8;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_HEIGHT = 2'd3;

    typedef enum logic [1:0] {
        COV_NONE   = 2'd0,
        COV_FIRST  = 2'd1,
        COV_SECOND = 2'd2,
        COV_BOTH   = 2'd3
    } cov_t;

    typedef struct packed {
        logic [SIDE_W-1:0] first_width;
        logic [SIDE_W-1:0] first_height;
        logic [SIDE_W-1:0] second_width;
        logic [SIDE_W-1:0] second_height;
    } cfg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } pixel_t;

endpackage

>>> rtl/core/caom_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caom_cfg
// Image size registers with write-side saturation to the largest side.
// ----------------------------------------------------------------------------
module caom_cfg
    import caom_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIDE_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);
    localparam logic [SIDE_W-1:0] SIDE_ONE = SIDE_W'(1);

    cfg_t              cfg_reg;
    logic [SIDE_W-1:0] value_sat;

    assign value_sat = (cfg_data > SIDE_MAX) ? SIDE_MAX : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_width   <= SIDE_ONE;
            cfg_reg.first_height  <= SIDE_ONE;
            cfg_reg.second_width  <= SIDE_ONE;
            cfg_reg.second_height <= SIDE_ONE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FIRST_WIDTH:   cfg_reg.first_width   <= value_sat;
                REG_FIRST_HEIGHT:  cfg_reg.first_height  <= value_sat;
                REG_SECOND_WIDTH:  cfg_reg.second_width  <= value_sat;
                REG_SECOND_HEIGHT: cfg_reg.second_height <= value_sat;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/caom_cover.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caom_cover
// Decides which of the two centered images covers a canvas pixel.
// ----------------------------------------------------------------------------
module caom_cover
    import caom_pkg::*;
(
    input  cfg_t               cfg,
    input  logic [COORD_W-1:0] x,
    input  logic [COORD_W-1:0] y,
    output cov_t               cov
);

    // p inside a span of length len centered on a canvas of length full
    function automatic logic span_hit(
        input logic [COORD_W-1:0] p,
        input logic [SIDE_W-1:0]  len,
        input logic [SIDE_W-1:0]  full
    );
        logic [SIDE_W-1:0] off;
        logic [SIDE_W:0]   stop;
        logic [SIDE_W:0]   pos;
        off  = (full - len) >> 1;
        stop = {1'b0, off} + {1'b0, len};
        pos  = (SIDE_W + 1)'(p);
        return (pos >= {1'b0, off}) && (pos < stop);
    endfunction

    logic [SIDE_W-1:0] canvas_w;
    logic [SIDE_W-1:0] canvas_h;
    logic              hit_first;
    logic              hit_second;

    assign canvas_w = (cfg.first_width > cfg.second_width) ?
                      cfg.first_width : cfg.second_width;
    assign canvas_h = (cfg.first_height > cfg.second_height) ?
                      cfg.first_height : cfg.second_height;

    assign hit_first  = span_hit(x, cfg.first_width, canvas_w) &&
                        span_hit(y, cfg.first_height, canvas_h);
    assign hit_second = span_hit(x, cfg.second_width, canvas_w) &&
                        span_hit(y, cfg.second_height, canvas_h);

    assign cov = cov_t'({hit_second, hit_first});

endmodule

>>> rtl/core/caom_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caom_blend
// Over compositing of the upper pixel onto the lower one in 8-bit fixed point.
// ----------------------------------------------------------------------------
module caom_blend
    import caom_pkg::*;
(
    input  pixel_t first_px,
    input  pixel_t second_px,
    input  cov_t   cov,
    output pixel_t res_px
);

    localparam int PROD_W = 2 * CHAN_W;
    localparam logic [CHAN_W-1:0] FULL = {CHAN_W{1'b1}};

    // round(v / 255) for v <= 255*255, without a divider:
    // t = v + 127, t / 255 = (t + 1 + (t >> 8)) >> 8 for t < 65535
    function automatic logic [CHAN_W-1:0] div255_round(input logic [PROD_W-1:0] v);
        logic [PROD_W:0] t;
        logic [PROD_W:0] q;
        t = {1'b0, v} + (PROD_W + 1)'(127);
        q = t + (PROD_W + 1)'(1) + (t >> CHAN_W);
        return q[PROD_W-1:CHAN_W];
    endfunction

    function automatic logic [CHAN_W-1:0] mix(
        input logic [CHAN_W-1:0] c1,
        input logic [CHAN_W-1:0] a1w,
        input logic [CHAN_W-1:0] c2,
        input logic [CHAN_W-1:0] a2
    );
        logic [PROD_W-1:0] sum;
        sum = (PROD_W'(c2) * PROD_W'(a2)) + (PROD_W'(a1w) * PROD_W'(c1));
        return div255_round(sum);
    endfunction

    logic [CHAN_W-1:0] room;
    logic [CHAN_W-1:0] a11;
    logic [CHAN_W-1:0] weight1;

    assign room = FULL - second_px.alpha;
    assign a11  = (first_px.alpha < room) ? first_px.alpha : room;
    // lower weight drops out when only the upper image covers
    assign weight1 = (cov == COV_BOTH) ? a11 : '0;

    always_comb
    begin
        case (cov)
            COV_BOTH, COV_SECOND:
            begin
                res_px.red   = mix(first_px.red,   weight1, second_px.red,   second_px.alpha);
                res_px.green = mix(first_px.green, weight1, second_px.green, second_px.alpha);
                res_px.blue  = mix(first_px.blue,  weight1, second_px.blue,  second_px.alpha);
                res_px.alpha = weight1 + second_px.alpha;
            end
            COV_FIRST:
            begin
                res_px = first_px;
            end
            default:
            begin
                res_px = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/centered_alpha_over_merge_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centered_alpha_over_merge_unit
// Merges two centered RGBA images one canvas pixel at a time, placing the
// upper image over the lower one with the over operator.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                   Payload
//  -------   -------------------------   --------------------------------------
//  in        in_valid / in_ready         out_x, out_y, first_*, second_*
//  out       out_valid / out_ready       res_red/green/blue/alpha, coverage
//  cfg       cfg_write (no wait)         cfg_index, cfg_data
//
//  One request per clock sustained while out_ready stays high. A request passes
//  an input register, then coverage decode plus the 8x8 multiply and
//  divide-by-255 into the result register.
//  Reset clears both valid flags and sets all four sizes to 1.
//  A stalled result holds in the result register; an empty input stage still
//  takes one request, but with both stages full in_ready drops in that cycle.
// ----------------------------------------------------------------------------
module centered_alpha_over_merge_unit
    import caom_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIDE_W-1:0]    cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [COORD_W-1:0]   out_x,
    input  logic [COORD_W-1:0]   out_y,
    input  logic [CHAN_W-1:0]    first_red,
    input  logic [CHAN_W-1:0]    first_green,
    input  logic [CHAN_W-1:0]    first_blue,
    input  logic [CHAN_W-1:0]    first_alpha,
    input  logic [CHAN_W-1:0]    second_red,
    input  logic [CHAN_W-1:0]    second_green,
    input  logic [CHAN_W-1:0]    second_blue,
    input  logic [CHAN_W-1:0]    second_alpha,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CHAN_W-1:0]    res_red,
    output logic [CHAN_W-1:0]    res_green,
    output logic [CHAN_W-1:0]    res_blue,
    output logic [CHAN_W-1:0]    res_alpha,
    output logic [1:0]           coverage
);

    cfg_t cfg;

    // input stage
    logic               s1_valid_reg;
    logic [COORD_W-1:0] s1_x_reg;
    logic [COORD_W-1:0] s1_y_reg;
    pixel_t             s1_first_reg;
    pixel_t             s1_second_reg;

    // result stage
    logic               res_valid_reg;
    pixel_t             res_px_reg;
    cov_t               res_cov_reg;

    logic   s1_advance;
    cov_t   cov_next;
    pixel_t res_px_next;

    caom_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stage 1 moves on when the result register is empty or being drained.
    assign s1_advance = !res_valid_reg || out_ready;
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_x_reg      <= out_x;
            s1_y_reg      <= out_y;
            s1_first_reg  <= '{red: first_red, green: first_green,
                               blue: first_blue, alpha: first_alpha};
            s1_second_reg <= '{red: second_red, green: second_green,
                               blue: second_blue, alpha: second_alpha};
        end
    end

    caom_cover u_cover (
        .cfg (cfg),
        .x   (s1_x_reg),
        .y   (s1_y_reg),
        .cov (cov_next)
    );

    caom_blend u_blend (
        .first_px  (s1_first_reg),
        .second_px (s1_second_reg),
        .cov       (cov_next),
        .res_px    (res_px_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            res_px_reg  <= res_px_next;
            res_cov_reg <= cov_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign res_red   = res_px_reg.red;
    assign res_green = res_px_reg.green;
    assign res_blue  = res_px_reg.blue;
    assign res_alpha = res_px_reg.alpha;
    assign coverage  = res_cov_reg;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the centered alpha-over merge unit against its own pixel predictor.
// Image sizes are set between phases through the write port; canvas pixels
// with random content and random coordinates stream through valid/ready
// channels with random gaps on both sides, and every merged pixel is
// compared field by field with the predicted one, in order.
// ----------------------------------------------------------------------------
module testbench;
    import caom_pkg::*;

    localparam int IDLE_PCT    = 31;    // chance in a hundred that a side idles
    localparam int STALL_LIMIT = 2000;  // cycles without any handshake
    localparam int CH_MAX      = 255;

    // One request: the canvas position and both source pixels.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        pixel_t             lower;
        pixel_t             upper;
    } pixel_req_t;

    // One merged pixel with its coverage code.
    typedef struct packed {
        pixel_t pix;
        cov_t   cov;
    } merge_res_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FIRST_WIDTH;
    logic [SIDE_W-1:0]    cfg_data  = '0;

    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [COORD_W-1:0]   out_x     = '0;
    logic [COORD_W-1:0]   out_y     = '0;
    logic [CHAN_W-1:0]    first_red    = '0;
    logic [CHAN_W-1:0]    first_green  = '0;
    logic [CHAN_W-1:0]    first_blue   = '0;
    logic [CHAN_W-1:0]    first_alpha  = '0;
    logic [CHAN_W-1:0]    second_red   = '0;
    logic [CHAN_W-1:0]    second_green = '0;
    logic [CHAN_W-1:0]    second_blue  = '0;
    logic [CHAN_W-1:0]    second_alpha = '0;

    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [CHAN_W-1:0]    res_red;
    logic [CHAN_W-1:0]    res_green;
    logic [CHAN_W-1:0]    res_blue;
    logic [CHAN_W-1:0]    res_alpha;
    logic [1:0]           coverage;

    // Period 12 ns: high half, low half.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    centered_alpha_over_merge_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .out_x        (out_x),
        .out_y        (out_y),
        .first_red    (first_red),
        .first_green  (first_green),
        .first_blue   (first_blue),
        .first_alpha  (first_alpha),
        .second_red   (second_red),
        .second_green (second_green),
        .second_blue  (second_blue),
        .second_alpha (second_alpha),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .res_red      (res_red),
        .res_green    (res_green),
        .res_blue     (res_blue),
        .res_alpha    (res_alpha),
        .coverage     (coverage)
    );

    // ------------------------------------------------------------------------
    // Shadow of the size registers, already saturated to MAX_SIDE
    // ------------------------------------------------------------------------
    int unsigned lower_w = 1;
    int unsigned lower_h = 1;
    int unsigned upper_w = 1;
    int unsigned upper_h = 1;

    pixel_req_t queued_pixels[$];   // requests not yet offered to the block
    merge_res_t awaited_merges[$];  // predicted pixels, oldest first

    int  pushed_count   = 0;        // requests queued by the sequencer
    int  accepted_count = 0;        // requests taken by the block
    bit  req_taken      = 1'b0;     // request handshake at the last rising edge
    bit  quiet          = 1'b0;     // no idling on either side while set
    int  mismatches     = 0;
    int  merged_count   = 0;
    int  size_settings  = 1;        // the reset sizes count as one
    int  cov_seen[4]    = '{0, 0, 0, 0};

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Does position p fall inside a span of length len centered on full?
    function automatic bit covers(int unsigned p, int unsigned len, int unsigned full);
        int unsigned off;
        off = (full - len) / 2;
        return (p >= off) && (p < off + len);
    endfunction

    // (c2*a2 + c1*a11 + 127) / 255, rounded fixed-point over
    function automatic logic [CHAN_W-1:0] blend(int unsigned c2, int unsigned a2,
                                                int unsigned c1, int unsigned a11);
        return CHAN_W'((c2 * a2 + c1 * a11 + 127) / 255);
    endfunction

    function automatic merge_res_t merge_pixel(pixel_req_t r);
        int unsigned cw;
        int unsigned ch;
        int unsigned a11;
        bit          hit_lo;
        bit          hit_up;
        merge_res_t  m;
        cw = (lower_w > upper_w) ? lower_w : upper_w;
        ch = (lower_h > upper_h) ? lower_h : upper_h;
        hit_lo = covers(r.x, lower_w, cw) && covers(r.y, lower_h, ch);
        hit_up = covers(r.x, upper_w, cw) && covers(r.y, upper_h, ch);
        m.cov  = cov_t'({hit_up, hit_lo});
        case (m.cov)
            COV_BOTH:
            begin
                a11 = CH_MAX - r.upper.alpha;
                if (r.lower.alpha < a11)
                    a11 = r.lower.alpha;
                m.pix.red   = blend(r.upper.red,   r.upper.alpha, r.lower.red,   a11);
                m.pix.green = blend(r.upper.green, r.upper.alpha, r.lower.green, a11);
                m.pix.blue  = blend(r.upper.blue,  r.upper.alpha, r.lower.blue,  a11);
                m.pix.alpha = CHAN_W'(a11 + r.upper.alpha);
            end
            COV_FIRST:
                m.pix = r.lower;
            COV_SECOND:
            begin
                // upper pixel alone comes out premultiplied
                m.pix.red   = blend(r.upper.red,   r.upper.alpha, 0, 0);
                m.pix.green = blend(r.upper.green, r.upper.alpha, 0, 0);
                m.pix.blue  = blend(r.upper.blue,  r.upper.alpha, 0, 0);
                m.pix.alpha = r.upper.alpha;
            end
            default:
                m.pix = '0;
        endcase
        return m;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: inputs change on the falling edge only
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : driver
        pixel_req_t next;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
            // a pending request holds until the block takes it
            if (!in_valid || req_taken)
            begin
                if (queued_pixels.size() != 0 &&
                    (quiet || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    next = queued_pixels.pop_front();
                    in_valid     <= 1'b1;
                    out_x        <= next.x;
                    out_y        <= next.y;
                    first_red    <= next.lower.red;
                    first_green  <= next.lower.green;
                    first_blue   <= next.lower.blue;
                    first_alpha  <= next.lower.alpha;
                    second_red   <= next.upper.red;
                    second_green <= next.upper.green;
                    second_blue  <= next.upper.blue;
                    second_alpha <= next.upper.alpha;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: both handshakes sampled on the rising edge
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    always @(posedge clk)
    begin : monitor
        pixel_req_t seen;
        merge_res_t want;
        req_taken = rst_n && in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            merged_count++;
            cov_seen[coverage]++;
            if (awaited_merges.size() == 0)
            begin
                report_mismatch("merged pixel with nothing pending", coverage, -1);
            end
            else
            begin
                want = awaited_merges.pop_front();
                if (res_red !== want.pix.red)
                    report_mismatch("res_red", res_red, want.pix.red);
                if (res_green !== want.pix.green)
                    report_mismatch("res_green", res_green, want.pix.green);
                if (res_blue !== want.pix.blue)
                    report_mismatch("res_blue", res_blue, want.pix.blue);
                if (res_alpha !== want.pix.alpha)
                    report_mismatch("res_alpha", res_alpha, want.pix.alpha);
                if (coverage !== want.cov)
                    report_mismatch("coverage", coverage, want.cov);
            end
        end
        // Sizes only change while idle, so the shadow is current here.
        if (req_taken)
        begin
            seen.x     = out_x;
            seen.y     = out_y;
            seen.lower = '{first_red, first_green, first_blue, first_alpha};
            seen.upper = '{second_red, second_green, second_blue, second_alpha};
            awaited_merges.push_back(merge_pixel(seen));
            accepted_count++;
        end
    end

    // Watchdog: too long without any handshake ends the run.
    int stall_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] no handshake for %0d cycles", $realtime, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer helpers
    // ------------------------------------------------------------------------
    function automatic pixel_t px(int r, int g, int b, int a);
        return '{CHAN_W'(r), CHAN_W'(g), CHAN_W'(b), CHAN_W'(a)};
    endfunction

    task automatic send(int x, int y, pixel_t lower, pixel_t upper);
        pixel_req_t r;
        r.x     = COORD_W'(x);
        r.y     = COORD_W'(y);
        r.lower = lower;
        r.upper = upper;
        queued_pixels.push_back(r);
        pushed_count++;
    endtask

    // Returns on a falling edge once every request is taken and merged.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (accepted_count != pushed_count || awaited_merges.size() != 0);
    endtask

    // Writes all four sizes, one per cycle; only called while drained.
    task automatic set_sizes(logic [SIDE_W-1:0] lw, logic [SIDE_W-1:0] lh,
                             logic [SIDE_W-1:0] uw, logic [SIDE_W-1:0] uh);
        logic [CFG_IDX_W-1:0] regs[4];
        logic [SIDE_W-1:0]    vals[4];
        int unsigned          sat;
        regs = '{REG_FIRST_WIDTH, REG_FIRST_HEIGHT, REG_SECOND_WIDTH, REG_SECOND_HEIGHT};
        vals = '{lw, lh, uw, uh};
        for (int i = 0; i < 4; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            sat = (vals[i] > MAX_SIDE) ? MAX_SIDE : vals[i];
            case (regs[i])
                REG_FIRST_WIDTH:   lower_w = sat;
                REG_FIRST_HEIGHT:  lower_h = sat;
                REG_SECOND_WIDTH:  upper_w = sat;
                default:           upper_h = sat;
            endcase
            @(negedge clk);
        end
        cfg_write <= 1'b0;
        size_settings++;
    endtask

    // Mostly small sizes; zero, the maximum and oversize values now and then.
    function automatic logic [SIDE_W-1:0] pick_side();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 7)
            return '0;
        else if (sel < 13)
            return SIDE_W'(MAX_SIDE);
        else if (sel < 18)
            return SIDE_W'($urandom_range(MAX_SIDE + 1, (1 << SIDE_W) - 1));
        else if (sel < 25)
            return SIDE_W'($urandom_range(1, (1 << SIDE_W) - 1));
        else
            return SIDE_W'($urandom_range(1, 12));
    endfunction

    // Alpha leans on fully transparent and fully opaque.
    function automatic int pick_alpha();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 2)
            return 0;
        else if (sel < 4)
            return CH_MAX;
        else
            return $urandom_range(0, CH_MAX);
    endfunction

    function automatic pixel_t random_pixel();
        return px($urandom_range(0, CH_MAX), $urandom_range(0, CH_MAX),
                  $urandom_range(0, CH_MAX), pick_alpha());
    endfunction

    // Mostly on or just past the canvas; some anywhere in coordinate space.
    task automatic send_random(int n);
        int unsigned cw;
        int unsigned ch;
        int unsigned x;
        int unsigned y;
        cw = (lower_w > upper_w) ? lower_w : upper_w;
        ch = (lower_h > upper_h) ? lower_h : upper_h;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                x = $urandom_range(0, (1 << COORD_W) - 1);
                y = $urandom_range(0, (1 << COORD_W) - 1);
            end
            else
            begin
                x = $urandom_range(0, cw + 1);
                y = $urandom_range(0, ch + 1);
                if (x >= (1 << COORD_W))
                    x = (1 << COORD_W) - 1;
                if (y >= (1 << COORD_W))
                    y = (1 << COORD_W) - 1;
            end
            send(x, y, random_pixel(), random_pixel());
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset sizes: a 1x1 canvas that both images cover.
        send(0, 0, px(255, 255, 255, 255), px(0, 0, 0, 0));
        send(0, 0, px(10, 20, 30, 40), px(255, 128, 1, 100));
        send(1, 0, px(255, 255, 255, 255), px(255, 255, 255, 255));
        send(4095, 4095, px(255, 255, 255, 255), px(255, 255, 255, 255));
        wait_drained();

        // Mixed sizes: canvas 4x5, lower at x 0..3 y 1..3, upper at x 1..2 y 0..4.
        set_sizes(13'd4, 13'd3, 13'd2, 13'd5);
        send(1, 1, px(255, 255, 255, 255), px(255, 0, 255, 255));  // opaque over opaque
        send(2, 2, px(255, 77, 0, 255), px(9, 9, 9, 0));           // clear upper
        send(1, 2, px(200, 100, 50, 0), px(60, 70, 80, 0));         // both clear
        send(2, 3, px(255, 255, 255, 200), px(255, 255, 255, 100)); // alpha sums to 255
        send(1, 3, px(17, 240, 99, 40), px(201, 3, 150, 100));      // lower alpha limits
        send(0, 1, px(1, 2, 3, 4), px(255, 255, 255, 255));         // lower only
        send(3, 3, px(0, 0, 0, 0), px(255, 255, 255, 255));
        send(1, 0, px(0, 0, 0, 0), px(255, 128, 7, 255));           // upper only
        send(2, 4, px(9, 9, 9, 9), px(255, 255, 255, 128));
        send(1, 4, px(9, 9, 9, 9), px(255, 255, 255, 0));
        send(0, 0, px(255, 255, 255, 255), px(255, 255, 255, 255)); // corner, neither
        send(4, 0, px(255, 255, 255, 255), px(255, 255, 255, 255)); // past right edge
        send(0, 5, px(255, 255, 255, 255), px(255, 255, 255, 255)); // past bottom edge
        wait_drained();

        // Zero width: the lower image covers nothing.
        set_sizes(13'd0, 13'd3, 13'd3, 13'd3);
        send(0, 0, px(255, 255, 255, 255), px(100, 150, 200, 50));
        send(2, 2, px(255, 255, 255, 255), px(255, 255, 255, 255));
        send(3, 1, px(255, 255, 255, 255), px(255, 255, 255, 255));
        wait_drained();

        // Oversize write saturates; 4096 square with a single upper pixel.
        set_sizes(13'd8191, 13'd4096, 13'd1, 13'd1);
        send(2047, 2047, px(4, 5, 6, 255), px(250, 251, 252, 3));
        send(2048, 2047, px(4, 5, 6, 255), px(250, 251, 252, 3));
        send(0, 0, px(255, 255, 255, 255), px(0, 0, 0, 0));
        send(4095, 4095, px(128, 64, 32, 16), px(0, 0, 0, 0));
        wait_drained();

        // Random phases, each with fresh sizes.
        for (int phase = 0; phase < 7; phase++)
        begin
            if (phase == 0)
                set_sizes(13'd7, 13'd5, 13'd3, 13'd9);
            else if (phase == 6)
                set_sizes(13'd4096, 13'd4096, 13'd4096, 13'd4096);
            else
                set_sizes(pick_side(), pick_side(), pick_side(), pick_side());
            quiet = (phase == 3);
            send_random(28);
            // sender holds off until the block has emptied
            wait_drained();
            send_random(27);
            wait_drained();
        end
        quiet = 1'b0;

        wait_drained();
        repeat (6) @(posedge clk);
        if (awaited_merges.size() != 0)
            report_mismatch("merged pixels never delivered", 0, awaited_merges.size());

        $display("Merged %0d pixels over %0d size settings", merged_count, size_settings);
        $display("Coverage none/lower/upper/both: %0d/%0d/%0d/%0d, mismatches: %0d",
                 cov_seen[COV_NONE], cov_seen[COV_FIRST], cov_seen[COV_SECOND],
                 cov_seen[COV_BOTH], mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/caom_pkg.sv
rtl/core/caom_cfg.sv
rtl/core/caom_cover.sv
rtl/core/caom_blend.sv
rtl/core/centered_alpha_over_merge_unit.sv
test/testbench.sv
